FILE: src/qrs_pkg.sv
// Package for the quadratic root solver: status codes and fixed widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int ROOT_W  = 34;
   localparam int DROOT_W = 33;
   localparam int STAT_W  = 2;
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NEG_DISC = 2'd1;
   localparam logic [STAT_W-1:0] STAT_A_ZERO   = 2'd2;
endpackage

FILE: src/qrs_disc.sv
// Discriminant stage: b*b and 4ac in one registered stage, the difference in the next.
// Depends on qrs_pkg for the status codes.
`timescale 1ns / 1ps
module qrs_disc #(
   parameter int CW = 16,
   parameter int DW = 2 * CW + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_a,
   input  logic signed [CW-1:0] in_b,
   input  logic signed [CW-1:0] in_c,
   output logic                 out_valid,
   output logic signed [CW-1:0] out_a,
   output logic signed [CW-1:0] out_b,
   output logic        [DW-2:0] out_disc,
   output logic [qrs_pkg::STAT_W-1:0] out_status
);
   logic                 v1_ff, v2_ff;
   logic signed [CW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DW-1:0] bb_ff, ac4_ff, d_in;
   logic        [DW-2:0] d_ff;
   logic [qrs_pkg::STAT_W-1:0] st_in, st_ff;

   // Products first, registered before the subtract.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      a1_ff  <= in_a;
      b1_ff  <= in_b;
      bb_ff  <= DW'(DW'(in_b) * DW'(in_b));
      ac4_ff <= DW'(DW'(in_a) * DW'(in_c)) <<< 2;
      a2_ff  <= a1_ff;
      b2_ff  <= b1_ff;
      d_ff   <= (d_in < 0) ? '0 : d_in[DW-2:0];
      st_ff  <= st_in;
   end

   // Classify the item: negative discriminant wins over a zero leading term.
   always_comb begin
      d_in = bb_ff - ac4_ff;
      if (d_in < 0) st_in = qrs_pkg::STAT_NEG_DISC;
      else if (a1_ff == '0) st_in = qrs_pkg::STAT_A_ZERO;
      else st_in = qrs_pkg::STAT_OK;
   end

   assign out_valid  = v2_ff;
   assign out_a      = a2_ff;
   assign out_b      = b2_ff;
   assign out_disc   = d_ff;
   assign out_status = st_ff;
endmodule

FILE: src/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, of disc * 2^(2*FB).
// Depends on qrs_pkg; carries the coefficients and status alongside.
`timescale 1ns / 1ps
module qrs_sqrt #(
   parameter int CW = 16,
   parameter int FB = 16,
   parameter int DW = 2 * CW + 1,
   parameter int RW = (DW + 1) / 2 + FB
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_a,
   input  logic signed [CW-1:0] in_b,
   input  logic        [DW-1:0] in_disc,
   input  logic [qrs_pkg::STAT_W-1:0] in_status,
   output logic                 out_valid,
   output logic signed [CW-1:0] out_a,
   output logic signed [CW-1:0] out_b,
   output logic        [RW-1:0] out_root,
   output logic [qrs_pkg::STAT_W-1:0] out_status
);
   localparam int XW = 2 * RW;
   logic                 v_ff   [RW+1];
   logic signed [CW-1:0] a_ff   [RW+1];
   logic signed [CW-1:0] b_ff   [RW+1];
   logic        [XW-1:0] x_ff   [RW+1];
   logic        [RW+1:0] rem_ff [RW+1];
   logic        [RW-1:0] r_ff   [RW+1];
   logic [qrs_pkg::STAT_W-1:0] st_ff [RW+1];

   // Stage zero loads the radicand; the rest of the line shifts with the data.
   always_comb begin
      v_ff[0]   = in_valid;
      a_ff[0]   = in_a;
      b_ff[0]   = in_b;
      x_ff[0]   = XW'(in_disc) << (2 * FB);
      rem_ff[0] = '0;
      r_ff[0]   = '0;
      st_ff[0]  = in_status;
   end

   for (genvar i = 0; i < RW; i++) begin : g_step
      logic [RW+1:0] rem_in, trial_in;
      // Bring down one bit pair and try to subtract 4r+1.
      always_comb begin
         rem_in   = {rem_ff[i][RW-1:0], x_ff[i][XW-1 -: 2]};
         trial_in = {r_ff[i], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         a_ff[i+1]  <= a_ff[i];
         b_ff[i+1]  <= b_ff[i];
         st_ff[i+1] <= st_ff[i];
         x_ff[i+1]  <= x_ff[i] << 2;
         if (rem_in >= trial_in) begin
            rem_ff[i+1] <= rem_in - trial_in;
            r_ff[i+1]   <= {r_ff[i][RW-2:0], 1'b1};
         end else begin
            rem_ff[i+1] <= rem_in;
            r_ff[i+1]   <= {r_ff[i][RW-2:0], 1'b0};
         end
      end
   end

   assign out_valid  = v_ff[RW];
   assign out_a      = a_ff[RW];
   assign out_b      = b_ff[RW];
   assign out_root   = r_ff[RW];
   assign out_status = st_ff[RW];
endmodule

FILE: src/qrs_div.sv
// Pipelined signed restoring divider for both roots, one quotient bit per stage.
// Depends on qrs_pkg for the status codes and output widths.
`timescale 1ns / 1ps
module qrs_div #(
   parameter int CW = 16,
   parameter int FB = 16,
   parameter int RW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_a,
   input  logic signed [CW-1:0] in_b,
   input  logic        [RW-1:0] in_root,
   input  logic [qrs_pkg::STAT_W-1:0] in_status,
   output logic                 out_valid,
   output logic [qrs_pkg::ROOT_W-1:0]  out_plus,
   output logic [qrs_pkg::ROOT_W-1:0]  out_minus,
   output logic [qrs_pkg::DROOT_W-1:0] out_root,
   output logic [qrs_pkg::STAT_W-1:0]  out_status
);
   // Numerator magnitude width: |b|*2^FB + s.
   localparam int NW = ((CW + FB + 1 > RW) ? CW + FB + 1 : RW) + 1;
   localparam int DV = CW + 1;
   localparam int SW = NW + 1;

   logic          v_ff  [NW+2];
   logic [RW-1:0] s_ff  [NW+2];
   logic [qrs_pkg::STAT_W-1:0] st_ff [NW+2];
   logic [DV-1:0] den_ff [NW+2];
   logic [NW-1:0] qp_ff [NW+2], qm_ff [NW+2];
   logic [NW-1:0] np_ff [NW+2], nm_ff [NW+2];
   logic [DV:0]   rp_ff [NW+2], rm_ff [NW+2];
   logic          sp_ff [NW+2], sm_ff [NW+2];

   // Setup stage: signed numerators reduced to magnitude and sign.
   logic signed [SW-1:0] nb_in, pn_in, mn_in;
   logic signed [DV-1:0] den_in;
   always_comb begin
      nb_in  = -(SW'(in_b) <<< FB);
      pn_in  = nb_in + SW'({1'b0, in_root});
      mn_in  = nb_in - SW'({1'b0, in_root});
      den_in = DV'(in_a) <<< 1;
   end

   always_comb begin
      v_ff[0] = in_valid; s_ff[0] = in_root; st_ff[0] = in_status;
      den_ff[0] = '0; qp_ff[0] = '0; qm_ff[0] = '0; np_ff[0] = '0; nm_ff[0] = '0;
      rp_ff[0] = '0; rm_ff[0] = '0; sp_ff[0] = 1'b0; sm_ff[0] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[1] <= 1'b0;
      else v_ff[1] <= v_ff[0];
      s_ff[1]   <= s_ff[0];
      st_ff[1]  <= st_ff[0];
      den_ff[1] <= den_in[DV-1] ? DV'(-den_in) : DV'(den_in);
      np_ff[1]  <= pn_in[SW-1] ? NW'(-pn_in) : NW'(pn_in);
      nm_ff[1]  <= mn_in[SW-1] ? NW'(-mn_in) : NW'(mn_in);
      sp_ff[1]  <= pn_in[SW-1] ^ den_in[DV-1];
      sm_ff[1]  <= mn_in[SW-1] ^ den_in[DV-1];
      qp_ff[1]  <= '0;
      qm_ff[1]  <= '0;
      rp_ff[1]  <= '0;
      rm_ff[1]  <= '0;
   end

   for (genvar i = 1; i <= NW; i++) begin : g_step
      logic [DV:0] tp_in, tm_in;
      // Shift in the next numerator bit and subtract when it fits.
      always_comb begin
         tp_in = {rp_ff[i][DV-1:0], np_ff[i][NW-1]};
         tm_in = {rm_ff[i][DV-1:0], nm_ff[i][NW-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         s_ff[i+1]   <= s_ff[i];
         st_ff[i+1]  <= st_ff[i];
         den_ff[i+1] <= den_ff[i];
         sp_ff[i+1]  <= sp_ff[i];
         sm_ff[i+1]  <= sm_ff[i];
         np_ff[i+1]  <= np_ff[i] << 1;
         nm_ff[i+1]  <= nm_ff[i] << 1;
         if (tp_in >= {1'b0, den_ff[i]}) begin
            rp_ff[i+1] <= tp_in - {1'b0, den_ff[i]};
            qp_ff[i+1] <= {qp_ff[i][NW-2:0], 1'b1};
         end else begin
            rp_ff[i+1] <= tp_in;
            qp_ff[i+1] <= {qp_ff[i][NW-2:0], 1'b0};
         end
         if (tm_in >= {1'b0, den_ff[i]}) begin
            rm_ff[i+1] <= tm_in - {1'b0, den_ff[i]};
            qm_ff[i+1] <= {qm_ff[i][NW-2:0], 1'b1};
         end else begin
            rm_ff[i+1] <= tm_in;
            qm_ff[i+1] <= {qm_ff[i][NW-2:0], 1'b0};
         end
      end
   end

   // Output stage: restore signs and zero the fields that the status voids.
   logic          ov_ff;
   logic [qrs_pkg::ROOT_W-1:0]  op_ff, om_ff;
   logic [qrs_pkg::DROOT_W-1:0] or_ff;
   logic [qrs_pkg::STAT_W-1:0]  os_ff;
   logic [NW:0] pq_in, mq_in;
   always_comb begin
      pq_in = sp_ff[NW+1] ? -{1'b0, qp_ff[NW+1]} : {1'b0, qp_ff[NW+1]};
      mq_in = sm_ff[NW+1] ? -{1'b0, qm_ff[NW+1]} : {1'b0, qm_ff[NW+1]};
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else ov_ff <= v_ff[NW+1];
      os_ff <= st_ff[NW+1];
      or_ff <= (st_ff[NW+1] == qrs_pkg::STAT_NEG_DISC) ? '0
             : qrs_pkg::DROOT_W'({{(qrs_pkg::DROOT_W){1'b0}}, s_ff[NW+1]});
      if (st_ff[NW+1] == qrs_pkg::STAT_OK) begin
         op_ff <= qrs_pkg::ROOT_W'({{(qrs_pkg::ROOT_W){pq_in[NW]}}, pq_in});
         om_ff <= qrs_pkg::ROOT_W'({{(qrs_pkg::ROOT_W){mq_in[NW]}}, mq_in});
      end else begin
         op_ff <= '0;
         om_ff <= '0;
      end
   end

   assign out_valid  = ov_ff;
   assign out_plus   = op_ff;
   assign out_minus  = om_ff;
   assign out_root   = or_ff;
   assign out_status = os_ff;

`ifndef SYNTHESIS
   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      ov_ff && os_ff != qrs_pkg::STAT_OK |-> op_ff == '0 && om_ff == '0)
      else $error("roots not zero for a void status");
   a_neg_root: assert property (@(posedge clock) disable iff (reset)
      ov_ff && os_ff == qrs_pkg::STAT_NEG_DISC |-> or_ff == '0)
      else $error("disc root not zero for a negative discriminant");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      v_ff[NW+1] |=> ov_ff)
      else $error("valid lost at the output stage");
`endif
endmodule

FILE: src/quadratic_root_solver.sv
// Quadratic root solver: discriminant, square root and divider pipelines.
// Throughput: one beat per cycle; busy stays low, since each stage is one register.
// The result beat shows for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on qrs_pkg, qrs_disc, qrs_sqrt and qrs_div.
`timescale 1ns / 1ps
module quadratic_root_solver #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_coef_a,
   input  logic [15:0] req_coef_b,
   input  logic [15:0] req_coef_c,
   output logic        rsp_valid,
   output logic [qrs_pkg::ROOT_W-1:0]  rsp_root_plus,
   output logic [qrs_pkg::ROOT_W-1:0]  rsp_root_minus,
   output logic [qrs_pkg::DROOT_W-1:0] rsp_disc_root,
   output logic [qrs_pkg::STAT_W-1:0]  rsp_status
);
   localparam int DW = 2 * COEF_WIDTH + 1;
   localparam int RW = (DW + 1) / 2 + FRAC_BITS;

   logic                         d_valid, s_valid;
   logic signed [COEF_WIDTH-1:0] d_a, d_b, s_a, s_b;
   logic [DW-1:0]                d_disc;
   logic [RW-1:0]                s_root;
   logic [qrs_pkg::STAT_W-1:0]   d_stat, s_stat;

   assign busy = 1'b0;

   // Coefficients are taken in their low COEF_WIDTH bits, zero-extended when wider.
   qrs_disc #(.CW(COEF_WIDTH)) u_disc (
      .clock(clock), .reset(reset), .in_valid(start),
      .in_a(COEF_WIDTH'(req_coef_a)), .in_b(COEF_WIDTH'(req_coef_b)),
      .in_c(COEF_WIDTH'(req_coef_c)),
      .out_valid(d_valid), .out_a(d_a), .out_b(d_b), .out_disc(d_disc),
      .out_status(d_stat));

   qrs_sqrt #(.CW(COEF_WIDTH), .FB(FRAC_BITS)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(d_valid), .in_a(d_a), .in_b(d_b),
      .in_disc(d_disc), .in_status(d_stat),
      .out_valid(s_valid), .out_a(s_a), .out_b(s_b), .out_root(s_root),
      .out_status(s_stat));

   qrs_div #(.CW(COEF_WIDTH), .FB(FRAC_BITS), .RW(RW)) u_div (
      .clock(clock), .reset(reset), .in_valid(s_valid), .in_a(s_a), .in_b(s_b),
      .in_root(s_root), .in_status(s_stat),
      .out_valid(rsp_valid), .out_plus(rsp_root_plus), .out_minus(rsp_root_minus),
      .out_root(rsp_disc_root), .out_status(rsp_status));
endmodule
